// File: src/utf8td_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8td_pkg
// Shared types and constants for the UTF-8 text detector.
// ----------------------------------------------------------------------------
package utf8td_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PEND_W    = 3;
    localparam int unsigned OUT_TDATA_W = 8;

    // byte masks and patterns
    localparam logic [7:0] TOP2_MASK   = 8'hC0;
    localparam logic [7:0] CONT_PATTERN = 8'h80;
    localparam logic [7:0] TERM_BYTE   = 8'h00;

    // classification of one text byte
    typedef struct packed {
        logic              is_term;   // zero byte ends the string
        logic              is_ascii;  // top bit clear
        logic              ascii_ok;  // allowed text character
        logic              is_cont;   // 10xxxxxx
        logic [PEND_W-1:0] lead_len;  // continuations due, 0 for bad lead
    } byte_class_t;

    // one result item
    typedef struct packed {
        logic still_possible;
        logic is_utf8;
        logic final_res;
    } result_t;

endpackage

// File: src/utf8_text_detector_unit.sv
`timescale 1ns / 1ps
// A byte accepted into the input register moves on to the result register, and
// so to the output, when the result register is empty or being taken.
// Throughput: one byte per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset: aresetn low clears both valid flags and the sequence state; the next
// byte after reset starts a fresh string.
// ----------------------------------------------------------------------------
// utf8_text_detector_unit
// Streams text bytes and reports per byte whether the string may still be
// UTF-8, with the final verdict on the zero terminator.
// ----------------------------------------------------------------------------
module utf8_text_detector_unit
    import utf8td_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] text_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic                   m_tlast,   // final_res
    output logic [OUT_TDATA_W-1:0] m_tdata    // [0] is_utf8, [1] still_possible,
                                              // [7:2] zero
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;
    logic              advance;
    logic              step;
    byte_class_t       cls;
    result_t           res;

    // the pipeline moves when the result register is free
    assign advance  = ~out_valid_reg | m_tready;
    assign step     = in_valid_reg & advance;
    assign s_tready = ~in_valid_reg | advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    utf8td_classify u_classify (
        .text_byte (in_byte_reg),
        .cls       (cls)
    );

    utf8td_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cls     (cls),
        .res     (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_res_reg.final_res;
    assign m_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, out_res_reg.still_possible,
                       out_res_reg.is_utf8};

`ifndef SYNTHESIS
    // a positive verdict is only given on the terminator of a live string
    a_verdict_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tlast && m_tdata[1]))
        else $error("is_utf8 set outside a final clean result");

    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    // a buffered byte reaches the empty result register next cycle
    a_fill_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("buffered byte did not advance");
`endif

endmodule

// File: src/utf8td_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8td_classify
// Decodes one text byte into its character class and lead length.
// ----------------------------------------------------------------------------
module utf8td_classify
    import utf8td_pkg::*;
(
    input  logic [BYTE_W-1:0] text_byte,
    output byte_class_t       cls
);

    // allowed ascii: printable range plus a few control characters
    logic printable;
    logic ctrl_ok;

    assign printable = (text_byte >= 8'h20) && (text_byte <= 8'h7E);
    assign ctrl_ok   = (text_byte == 8'h07) || (text_byte == 8'h08) ||
                       (text_byte == 8'h09) || (text_byte == 8'h0A) ||
                       (text_byte == 8'h0C) || (text_byte == 8'h0D) ||
                       (text_byte == 8'h1B);

    // lead length from the first zero bit below the top two
    always_comb begin
        cls.is_term  = (text_byte == TERM_BYTE);
        cls.is_ascii = ~text_byte[7];
        cls.ascii_ok = printable | ctrl_ok;
        cls.is_cont  = ((text_byte & TOP2_MASK) == CONT_PATTERN);
        if (!text_byte[5]) begin
            cls.lead_len = 3'd1;
        end else if (!text_byte[4]) begin
            cls.lead_len = 3'd2;
        end else if (!text_byte[3]) begin
            cls.lead_len = 3'd3;
        end else if (!text_byte[2]) begin
            cls.lead_len = 3'd4;
        end else if (!text_byte[1]) begin
            cls.lead_len = 3'd5;
        end else begin
            cls.lead_len = 3'd0;
        end
    end

endmodule

// File: src/utf8td_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8td_track
// Holds the per-string sequence state and forms the result for each byte.
// ----------------------------------------------------------------------------
module utf8td_track
    import utf8td_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  byte_class_t cls,
    output result_t     res
);

    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              seen_reg, seen_next;
    logic              rej_reg,  rej_next;

    // next state and result for the byte in the input register
    always_comb begin
        pend_next = pend_reg;
        seen_next = seen_reg;
        rej_next  = rej_reg;
        res.final_res      = 1'b0;
        res.is_utf8        = 1'b0;
        res.still_possible = 1'b0;
        if (cls.is_term) begin
            res.final_res      = 1'b1;
            res.is_utf8        = ~rej_reg & seen_reg;
            res.still_possible = ~rej_reg;
            pend_next = '0;
            seen_next = 1'b0;
            rej_next  = 1'b0;
        end else begin
            if (!rej_reg) begin
                if (pend_reg != '0) begin
                    if (!cls.is_cont) begin
                        rej_next  = 1'b1;
                        pend_next = '0;
                    end else begin
                        pend_next = pend_reg - 3'd1;
                        if (pend_reg == 3'd1) begin
                            seen_next = 1'b1;
                        end
                    end
                end else if (cls.is_ascii) begin
                    if (!cls.ascii_ok) begin
                        rej_next = 1'b1;
                    end
                end else if (cls.is_cont) begin
                    rej_next = 1'b1;
                end else if (cls.lead_len == '0) begin
                    rej_next = 1'b1;
                end else begin
                    pend_next = cls.lead_len;
                end
            end
            res.still_possible = ~rej_next;
        end
    end

    // state advances when the byte moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            seen_reg <= 1'b0;
            rej_reg  <= 1'b0;
        end else if (step) begin
            pend_reg <= pend_next;
            seen_reg <= seen_next;
            rej_reg  <= rej_next;
        end
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for utf8_text_detector_unit. A short table of
// hand-picked strings comes first: empty string, a two-byte character, bad
// leads, a stray continuation, a disallowed control byte, the longest lead
// with five continuations, a broken sequence and a sequence cut off by the
// terminator. Random strings follow, mostly well-formed UTF-8 with random
// content, some with noise bytes or truncated sequences. Each result is
// checked against its table row's result or a per-byte detector model, with
// random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import utf8td_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200_000;
    localparam int unsigned TEXT_BYTES   = 650;
    localparam int unsigned CALM_FROM    = 530;
    localparam int unsigned MAX_REPORTS  = 10;

    // allowed ASCII control characters
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_HT  = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    // results that can be read off directly
    localparam result_t RES_OPEN      = '{still_possible: 1'b1, is_utf8: 1'b0, final_res: 1'b0};
    localparam result_t RES_REJECTED  = '{still_possible: 1'b0, is_utf8: 1'b0, final_res: 1'b0};
    localparam result_t RES_END_PLAIN = '{still_possible: 1'b1, is_utf8: 1'b0, final_res: 1'b1};
    localparam result_t RES_END_REJ   = '{still_possible: 1'b0, is_utf8: 1'b0, final_res: 1'b1};

    typedef struct packed {
        logic [7:0] text;
        logic       typed;
        result_t    want;
    } text_row_t;

    localparam int unsigned N_ROWS = 27;
    localparam text_row_t TEXT_ROWS [N_ROWS] = '{
        '{8'h00, 1'b1, RES_END_PLAIN},   // empty string after reset
        '{8'h41, 1'b1, RES_OPEN},
        '{8'hC3, 1'b0, RES_OPEN},        // two-byte character
        '{8'hA9, 1'b0, RES_OPEN},
        '{8'h00, 1'b0, RES_OPEN},
        '{8'hFF, 1'b1, RES_REJECTED},    // invalid lead
        '{8'h41, 1'b1, RES_REJECTED},    // ignored after rejection
        '{8'h00, 1'b1, RES_END_REJ},
        '{8'h80, 1'b1, RES_REJECTED},    // stray continuation
        '{8'h00, 1'b1, RES_END_REJ},
        '{8'hFE, 1'b1, RES_REJECTED},    // invalid lead
        '{8'h00, 1'b1, RES_END_REJ},
        '{8'hFD, 1'b0, RES_OPEN},        // longest lead, five continuations
        '{8'hBF, 1'b0, RES_OPEN},
        '{8'hBF, 1'b0, RES_OPEN},
        '{8'hBF, 1'b0, RES_OPEN},
        '{8'hBF, 1'b0, RES_OPEN},
        '{8'hBF, 1'b0, RES_OPEN},
        '{8'h00, 1'b0, RES_OPEN},
        '{8'hE2, 1'b0, RES_OPEN},        // non-continuation where one is due
        '{8'h41, 1'b0, RES_OPEN},
        '{8'h00, 1'b0, RES_OPEN},
        '{8'hF0, 1'b0, RES_OPEN},        // terminator inside a sequence
        '{8'h9F, 1'b0, RES_OPEN},
        '{8'h00, 1'b0, RES_OPEN},
        '{8'h7F, 1'b0, RES_OPEN},        // disallowed control byte
        '{8'h00, 1'b0, RES_OPEN}
    };

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   m_tlast;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // model state
    logic [PEND_W-1:0] cont_due;
    logic              multibyte_done;
    logic              text_rejected;

    result_t     verdict_q [$];
    result_t     want_res;
    result_t     got_res;
    int unsigned bytes_sent;
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned stall_left;
    logic        calm;

    utf8_text_detector_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_tdata  (m_tdata)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // per-byte model of the detector
    function automatic result_t judge_byte(input logic [7:0] text);
        result_t          r;
        logic [PEND_W-1:0] lead_n;
        r = '0;
        if (text == TERM_BYTE) begin
            r.final_res      = 1'b1;
            r.is_utf8        = !text_rejected && multibyte_done;
            r.still_possible = !text_rejected;
            cont_due         = '0;
            multibyte_done   = 1'b0;
            text_rejected    = 1'b0;
            return r;
        end
        if (!text_rejected) begin
            if (cont_due != '0) begin
                if ((text & TOP2_MASK) != CONT_PATTERN) begin
                    text_rejected = 1'b1;
                    cont_due      = '0;
                end else begin
                    cont_due = cont_due - 3'd1;
                    if (cont_due == '0) multibyte_done = 1'b1;
                end
            end else if (!text[7]) begin
                if (!((text >= PRINT_LO && text <= PRINT_HI) ||
                      text inside {CH_BEL, CH_BS, CH_HT, CH_LF, CH_FF, CH_CR, CH_ESC}))
                    text_rejected = 1'b1;
            end else if (!text[6]) begin
                text_rejected = 1'b1;
            end else begin
                // the first zero bit below the leading 11 gives the continuations due
                lead_n = !text[5] ? 3'd1 : !text[4] ? 3'd2 : !text[3] ? 3'd3 :
                         !text[2] ? 3'd4 : !text[1] ? 3'd5 : 3'd0;
                if (lead_n == '0) text_rejected = 1'b1;
                else              cont_due = lead_n;
            end
        end
        r.still_possible = !text_rejected;
        return r;
    endfunction

    // one request on the input channel, sometimes with a random idle burst ahead of it
    task automatic send_byte(input logic [7:0] text, input logic typed = 1'b0,
                             input result_t want = '0);
        result_t predicted;
        if (!calm && $urandom_range(0, 6) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= text;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = judge_byte(text);
        verdict_q.push_back(typed ? want : predicted);
        bytes_sent++;
    endtask

    // hold the sender until every expected result is out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
    endtask

    // one random string: mostly well-formed, some with noise or truncation
    task automatic send_text();
        int unsigned kind;
        int unsigned n_chars;
        int unsigned n_cont;
        int unsigned keep;
        logic [7:0]  lead;
        kind    = $urandom_range(0, 9);
        n_chars = $urandom_range(0, 8);
        for (int i = 0; i < n_chars; i++) begin
            if (kind == 9 || (kind == 7 && $urandom_range(0, 3) == 0))
                send_byte(8'($urandom_range(1, 255)));
            if (kind == 9) continue;
            if ($urandom_range(0, 1) == 1) begin
                if ($urandom_range(0, 7) == 0)
                    send_byte(CH_BEL + 8'($urandom_range(0, 6)) == CH_BS + 8'd3 ?
                              CH_ESC : CH_BEL + 8'($urandom_range(0, 6)));
                else
                    send_byte(8'($urandom_range(PRINT_LO, PRINT_HI)));
            end else begin
                n_cont = $urandom_range(1, 5);
                lead   = (8'hFF << (7 - n_cont)) | (8'($urandom) & (8'hFF >> (n_cont + 2)));
                send_byte(lead);
                keep = n_cont;
                if (kind == 8 && i == n_chars - 1) keep = $urandom_range(0, n_cont - 1);
                for (int k = 0; k < keep; k++)
                    send_byte(CONT_PATTERN | 8'($urandom_range(0, 63)));
            end
        end
        send_byte(TERM_BYTE);
    endtask

    // receiver stalls in bursts of random length
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res = result_t'({m_tdata[1], m_tdata[0], m_tlast});
            if (verdict_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result last %b data %b at cycle %0d",
                             m_tlast, m_tdata, cycle_count);
            end else begin
                want_res = verdict_q.pop_front();
                if (got_res.final_res != want_res.final_res ||
                    got_res.is_utf8 != want_res.is_utf8 ||
                    got_res.still_possible != want_res.still_possible ||
                    m_tdata[OUT_TDATA_W-1:2] != '0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"mismatch at cycle %0d: final/utf8/possible ",
                                  "expected %b/%b/%b got %b/%b/%b (tdata %b)"},
                                 cycle_count, want_res.final_res, want_res.is_utf8,
                                 want_res.still_possible, got_res.final_res,
                                 got_res.is_utf8, got_res.still_possible, m_tdata);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        cont_due       = '0;
        multibyte_done = 1'b0;
        text_rejected  = 1'b0;
        bytes_sent     = 0;
        fail_count     = 0;
        cycle_count    = 0;
        stall_left     = 0;
        calm           = 1'b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed strings
        for (int r = 0; r < N_ROWS; r++)
            send_byte(TEXT_ROWS[r].text, TEXT_ROWS[r].typed, TEXT_ROWS[r].want);
        drain_results();

        // random strings, full drains around the midpoint, no idling near the end
        while (bytes_sent < TEXT_BYTES) begin
            if (bytes_sent >= TEXT_BYTES / 2 && bytes_sent < TEXT_BYTES / 2 + 12)
                drain_results();
            if (bytes_sent >= CALM_FROM) calm = 1'b1;
            send_text();
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && verdict_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
